FILE: design/assert_macros.svh
// Assertion macros shared by the downsampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define RBD_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rbd_pkg.sv
// Shared types and constants for the 2x2 box downsampler.
`timescale 1ns / 1ps
`default_nettype none
package rbd_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CFG_W         = 11;
    localparam int PIX_W         = 32;
    localparam int NUM_CH        = 4;
    localparam int CH_W          = 8;
    localparam int QTR_W         = 6;
    localparam int HELD_W        = NUM_CH * QTR_W;
    localparam int MIN_SCALE_W   = 64;
    localparam int QTR_SHIFT     = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic [PIX_W-1:0]  QUARTER_MASK = 32'hFCFCFCFC;
    localparam logic [CFG_W-1:0]  SIZE_RESET   = 11'd64;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } rbd_reg_t;

    // Work carried from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_PASS  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_EMIT  = 2'd2
    } rbd_op_t;

    typedef struct packed {
        rbd_op_t            op;
        logic               last;
        logic [PIX_W-1:0]   data;
    } rbd_cmd_t;

    // Configuration handed to the front end.
    typedef struct packed {
        logic [CFG_W-1:0]   width;
        logic [CFG_W-1:0]   height;
        logic               clear;
    } rbd_cfg_t;

endpackage
`default_nettype wire

FILE: design/rbd_front.sv
// Front end: counts pixels, chooses the mode and builds the work for the back end.
`timescale 1ns / 1ps
`default_nettype none
module rbd_front #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH / 2)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rbd_pkg::rbd_cfg_t          cfg,
    input  wire logic [rbd_pkg::PIX_W-1:0]  pixel_in,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       queue_full,
    output logic                            push,
    output rbd_pkg::rbd_cmd_t               push_cmd,
    output logic [AW-1:0]                   push_idx
);
    import rbd_pkg::*;
    `include "assert_macros.svh"

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (SW > CFG_W) ? SW : CFG_W;

    logic [CW-1:0]     column_count_reg, column_count_next;
    logic [CW-1:0]     row_count_reg, row_count_next;
    logic [HELD_W-1:0] held_left_reg, held_left_next;

    logic [SW-1:0]     eff_w, eff_h, w_even, h_even;
    logic [SW-1:0]     col_ext, row_ext, col_plus, row_plus;
    logic [CMP_W-1:0]  w_raw, h_raw;
    logic              accept, scale_mode, in_area, col_end;
    logic [PIX_W-1:0]  quarter, pair;
    logic [HELD_W-1:0] quarter_packed;

    // Clamp the programmed sizes to 1..MAX_WIDTH, the range that the line store covers.
    always_comb
    begin
        w_raw = CMP_W'(cfg.width);
        h_raw = CMP_W'(cfg.height);
        if (cfg.width == '0)
            eff_w = SW'(1);
        else if (w_raw > CMP_W'(MAX_WIDTH))
            eff_w = SW'(MAX_WIDTH);
        else
            eff_w = SW'(w_raw);
        if (cfg.height == '0)
            eff_h = SW'(1);
        else if (h_raw > CMP_W'(MAX_WIDTH))
            eff_h = SW'(MAX_WIDTH);
        else
            eff_h = SW'(h_raw);
        w_even = {eff_w[SW-1:1], 1'b0};
        h_even = {eff_h[SW-1:1], 1'b0};
    end

    assign accept     = in_valid && !queue_full;
    assign in_stall   = queue_full;
    assign col_ext    = SW'(column_count_reg);
    assign row_ext    = SW'(row_count_reg);
    assign col_plus   = col_ext + SW'(1);
    assign row_plus   = row_ext + SW'(1);
    assign col_end    = (col_plus >= eff_w);
    assign scale_mode = (eff_w == eff_h) && (eff_w >= SW'(MIN_SCALE_W));
    assign in_area    = (col_ext < w_even) && (row_ext < h_even);

    // Quarter every channel and add the held left neighbour, channel by channel.
    always_comb
    begin
        quarter = (pixel_in & QUARTER_MASK) >> QTR_SHIFT;
        for (int k = 0; k < NUM_CH; k++)
        begin
            quarter_packed[k*QTR_W +: QTR_W] = quarter[k*CH_W +: QTR_W];
            pair[k*CH_W +: CH_W] = {2'b00, held_left_reg[k*QTR_W +: QTR_W]}
                                 + quarter[k*CH_W +: CH_W];
        end
    end

    // Classify the pixel and advance the raster counters.
    always_comb
    begin
        push              = 1'b0;
        push_cmd.op       = CMD_PASS;
        push_cmd.last     = 1'b0;
        push_cmd.data     = pixel_in;
        push_idx          = column_count_reg[AW:1];
        held_left_next    = held_left_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;

        if (accept)
        begin
            if (!scale_mode)
            begin
                push          = 1'b1;
                push_cmd.last = col_end && (row_plus >= eff_h);
            end
            else if (in_area)
            begin
                if (!column_count_reg[0])
                    held_left_next = quarter_packed;
                else
                begin
                    push          = 1'b1;
                    push_cmd.data = pair;
                    if (!row_count_reg[0])
                        push_cmd.op = CMD_STORE;
                    else
                    begin
                        push_cmd.op   = CMD_EMIT;
                        push_cmd.last = (col_plus == w_even) && (row_plus == h_even);
                    end
                end
            end

            if (col_end)
            begin
                column_count_next = '0;
                row_count_next    = (row_plus >= eff_h) ? '0 : row_plus[CW-1:0];
            end
            else
                column_count_next = col_plus[CW-1:0];
        end

        // A register write starts a new image.
        if (cfg.clear)
        begin
            column_count_next = '0;
            row_count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            held_left_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            held_left_reg    <= held_left_next;
        end
    end

    `RBD_ASSERT_ALWAYS(a_col_in_row, clk, rst_n, (col_ext < eff_w) && (row_ext < eff_h),
        "front: raster position outside the image")

endmodule
`default_nettype wire

FILE: design/rbd_queue.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
module rbd_queue #(
    parameter int WIDTH = rbd_pkg::PIX_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic                    head_valid,
    output logic [WIDTH-1:0]        head_data,
    output logic                    full
);
    import rbd_pkg::*;
    `include "assert_macros.svh"

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == NW'(QUEUE_DEPTH));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `RBD_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full,
        "queue: push while full")
    `RBD_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, head_valid,
        "queue: pop while empty")

endmodule
`default_nettype wire

FILE: design/rbd_back.sv
// Back end: keeps the even-row pair sums and forms the output transactions.
`timescale 1ns / 1ps
`default_nettype none
module rbd_back #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH / 2)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_valid,
    input  wire rbd_pkg::rbd_cmd_t          head_cmd,
    input  wire logic [AW-1:0]              head_idx,
    output logic                            pop,
    output logic [rbd_pkg::PIX_W-1:0]       pixel_out,
    output logic                            last_of_image,
    output logic                            out_valid,
    input  wire logic                       out_stall
);
    import rbd_pkg::*;
    `include "assert_macros.svh"

    localparam int PAIR_SLOTS = MAX_WIDTH / 2;

    logic [PIX_W-1:0] pair_mem [PAIR_SLOTS];
    logic [PIX_W-1:0] rd_data_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_pass_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] s1_data_reg;

    logic             out_valid_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] out_data_reg;

    logic             out_free, s1_free, is_store, is_emit, is_pass;

    // Stores never wait; results only move when the stage ahead has room.
    always_comb
    begin
        is_store = 1'b0;
        is_emit  = 1'b0;
        is_pass  = 1'b0;
        case (head_cmd.op)
            CMD_STORE: is_store = 1'b1;
            CMD_EMIT:  is_emit  = 1'b1;
            CMD_PASS:  is_pass  = 1'b1;
            default:   is_pass  = 1'b0;
        endcase
    end

    assign out_free      = !out_valid_reg || !out_stall;
    assign s1_free       = !s1_valid_reg || out_free;
    assign pop           = head_valid && (is_store || ((is_emit || is_pass) && s1_free));
    assign s1_valid_next = s1_free ? (pop && !is_store) : s1_valid_reg;

    // Line store of even-row sums, read data registered.
    always_ff @(posedge clk)
    begin
        if (pop && is_store)
            pair_mem[head_idx] <= head_cmd.data;
        if (pop && is_emit)
            rd_data_reg <= pair_mem[head_idx];
    end

    // Read stage and output register: control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Read stage and output register: payload.
    always_ff @(posedge clk)
    begin
        if (pop && !is_store)
        begin
            s1_pass_reg <= is_pass;
            s1_last_reg <= head_cmd.last;
            s1_data_reg <= head_cmd.data;
        end
        if (out_free && s1_valid_reg)
        begin
            out_last_reg <= s1_last_reg;
            out_data_reg <= s1_pass_reg ? s1_data_reg : rd_data_reg + s1_data_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_out     = out_data_reg;
    assign last_of_image = out_last_reg;

    `RBD_ASSERT_NEXT(a_emit_reaches_stage, clk, rst_n, pop && !is_store, s1_valid_reg,
        "back: popped result did not enter the read stage")
    `RBD_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !out_free, s1_valid_reg,
        "back: read stage lost a result while blocked")

endmodule
`default_nettype wire

FILE: design/rgba_box_downsample_2x2.sv
// Top level of the RGBA 2x2 box downsampler with its configuration registers.
//
// Usage:
//   Pixels enter on pixel_in with in_valid/in_stall in raster order, one
//   32-bit pixel of four 8-bit channels per transaction. Results leave on
//   pixel_out and last_of_image with out_valid/out_stall; last_of_image marks
//   the final result of an image.
//   Registers on the APB port: image_width at 0x0, image_height at 0x4.
//   Any register write restarts the raster position at the top left.
//   When width equals height and is at least 64, each 2x2 block gives one
//   averaged result (odd last column or row dropped); otherwise every pixel
//   passes through unchanged.
//   Throughput: one input pixel per clock while the queue is not full. A
//   result passes through the queue slot, the line store read stage and the
//   output register, in that order.
//   Reset sets both sizes to 64 and the raster position to zero; the line
//   store needs no clearing because every sum is written before it is read.
//   When the receiver stalls, the output holds its transaction, the four-entry
//   queue fills, and in_stall rises once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module rgba_box_downsample_2x2 #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rbd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [rbd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rbd_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,
    input  wire logic [rbd_pkg::PIX_W-1:0]          pixel_in,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    output logic [rbd_pkg::PIX_W-1:0]               pixel_out,
    output logic                                    last_of_image,
    output logic                                    out_valid,
    input  wire logic                               out_stall
);
    import rbd_pkg::*;

    localparam int AW      = $clog2(MAX_WIDTH / 2);
    localparam int CMD_W   = $bits(rbd_cmd_t);
    localparam int ENTRY_W = AW + CMD_W;

    logic [CFG_W-1:0] image_width_reg, image_width_next;
    logic [CFG_W-1:0] image_height_reg, image_height_next;
    logic             cfg_write;
    rbd_reg_t         reg_sel;
    rbd_cfg_t         cfg;

    logic             push, pop, queue_full, head_valid;
    rbd_cmd_t         push_cmd;
    logic [AW-1:0]    push_idx;
    logic [ENTRY_W-1:0] head_data;

    // Register file behind the APB port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = rbd_reg_t'(paddr[2]);

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        prdata            = '0;
        case (reg_sel)
            REG_IMAGE_WIDTH:
            begin
                prdata = APB_DATA_W'(image_width_reg);
                if (cfg_write)
                    image_width_next = pwdata[CFG_W-1:0];
            end
            REG_IMAGE_HEIGHT:
            begin
                prdata = APB_DATA_W'(image_height_reg);
                if (cfg_write)
                    image_height_next = pwdata[CFG_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= SIZE_RESET;
            image_height_reg <= SIZE_RESET;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    assign cfg.width  = image_width_reg;
    assign cfg.height = image_height_reg;
    assign cfg.clear  = cfg_write;

    rbd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pixel_in   (pixel_in),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_idx   (push_idx)
    );

    rbd_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_idx, push_cmd}),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (queue_full)
    );

    rbd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (rbd_cmd_t'(head_data[CMD_W-1:0])),
        .head_idx      (head_data[ENTRY_W-1:CMD_W]),
        .pop           (pop),
        .pixel_out     (pixel_out),
        .last_of_image (last_of_image),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

endmodule
`default_nettype wire
